@@ sv/text_console_writer_assert.svh @@
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// checked outside reset
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define TCW_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int RROW_W    = 5;
    localparam int RCOL_W    = 7;
    localparam int CELL_W    = 16;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;
    localparam int COLOR_W   = 8;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [RROW_W-1:0] read_row;
        logic [RCOL_W-1:0] read_col;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
        logic                 scrolled;
    } t_res;

endpackage

@@ sv/tcw_cmd_if.sv @@
// ----------------------------------------------------------------------------
// tcw_cmd_if
// command channel of the text console writer
// ----------------------------------------------------------------------------
interface tcw_cmd_if import tcw_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;

    modport source (output valid, output command, output char_code,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input command, input char_code,
                    input read_row, input read_col, output ready);

endinterface

@@ sv/tcw_res_if.sv @@
// ----------------------------------------------------------------------------
// tcw_res_if
// result channel of the text console writer
// ----------------------------------------------------------------------------
interface tcw_res_if import tcw_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 scrolled;

    modport source (output valid, output cell_value, output cursor_row,
                    output cursor_col, output scrolled, input ready);
    modport sink   (input valid, input cell_value, input cursor_row,
                    input cursor_col, input scrolled, output ready);

endinterface

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// character cell console: screen in one ram, rows kept as a ring so that a
// scroll moves the top row pointer and refills one row
// ----------------------------------------------------------------------------
// character or newline: ST_EXEC, result registered, ST_DONE while stalled
// read cell: ST_EXEC, registered ram read in ST_READ, result registered
// scroll: ST_FILL, one ram write per cell of the new bottom row
// clear: ST_CLEAR, one ram write per cell
// reset: ST_INIT blanking pass of the ram, no item taken meanwhile
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COLOR_W-1:0] i_cfg_wdata,
    tcw_cmd_if.sink            i_cmd,
    tcw_res_if.source          o_res
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    t_state              r_state, n_state;
    t_item               r_item;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_top, n_top;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [COLOR_W-1:0]  r_color;
    logic                r_rd_ok, n_rd_ok;
    t_res                r_out, n_out;
    logic                r_out_valid, n_out_valid;
    t_res                r_pend, n_pend;

    logic                slot_free;
    logic                fin;
    t_res                fin_res;
    logic                is_nl;
    logic                wrap;
    logic                adv_row;
    logic                scroll;
    logic                cnt_last_cell;
    logic                cnt_last_col;

    logic [ROW_W-1:0]    am_row;
    logic [COL_W-1:0]    am_col;
    logic [ADDR_W-1:0]   am_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [CELL_W-1:0]   ram_rdata;

    tcw_addr #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_tcw_addr (
        .i_row  (am_row),
        .i_col  (am_col),
        .i_top  (r_top),
        .o_addr (am_addr)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_tcw_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (am_addr),
        .o_rdata (ram_rdata)
    );

    assign slot_free     = !r_out_valid || o_res.ready;
    assign is_nl         = (r_item.char_code == NEWLINE_CODE);
    assign wrap          = !is_nl && (r_col == COL_LAST);
    assign adv_row       = (r_item.command == CMD_WRITE) && (is_nl || wrap);
    assign scroll        = adv_row && (r_row == ROW_LAST);
    assign cnt_last_cell = (r_cnt == CELL_LAST);
    assign cnt_last_col  = (r_cnt[COL_W-1:0] == COL_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (cnt_last_cell) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_item.command == CMD_READ) begin
                    n_state = ST_READ;
                end else if (r_item.command == CMD_CLEAR) begin
                    n_state = ST_CLEAR;
                end else if (scroll) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = slot_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_READ: begin
                n_state = slot_free ? ST_IDLE : ST_DONE;
            end
            ST_FILL: begin
                if (cnt_last_col) begin
                    n_state = slot_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (cnt_last_cell) begin
                    n_state = slot_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_top     = r_top;
        n_cnt     = r_cnt;
        n_rd_ok   = r_rd_ok;
        n_pend    = r_pend;
        fin       = 1'b0;
        am_row    = r_row;
        am_col    = r_col;
        ram_we    = 1'b0;
        ram_waddr = am_addr;
        ram_wdata = {r_color, r_item.char_code};
        fin_res   = '0;

        unique case (r_state) inside
            ST_INIT, ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = BLANK_CELL;
                n_cnt     = cnt_last_cell ? '0 : r_cnt + ADDR_W'(1);
                fin       = (r_state == ST_CLEAR) && cnt_last_cell;
            end
            ST_EXEC: begin
                unique case (r_item.command)
                    CMD_WRITE: begin
                        ram_we = !is_nl;
                        if (is_nl || wrap) begin
                            n_col = '0;
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                        if (adv_row && !scroll) begin
                            n_row = r_row + ROW_W'(1);
                        end
                        if (scroll) begin
                            n_top = (r_top == ROW_LAST) ? '0 : r_top + ROW_W'(1);
                            n_cnt = '0;
                        end
                        fin = !scroll;
                    end
                    CMD_READ: begin
                        am_row  = ROW_W'(r_item.read_row);
                        am_col  = COL_W'(r_item.read_col);
                        n_rd_ok = (r_item.read_row < ROWS) && (r_item.read_col < COLUMNS);
                    end
                    CMD_CLEAR: begin
                        n_row = '0;
                        n_col = '0;
                        n_top = '0;
                        n_cnt = '0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                fin                = 1'b1;
                fin_res.cell_value = r_rd_ok ? ram_rdata : '0;
            end
            ST_FILL: begin
                am_row    = ROW_LAST;
                am_col    = r_cnt[COL_W-1:0];
                ram_we    = 1'b1;
                ram_wdata = {r_color, SPACE_CODE};
                n_cnt     = r_cnt + ADDR_W'(1);
                fin       = cnt_last_col;
                fin_res.scrolled = 1'b1;
            end
            ST_DONE: begin
                fin = 1'b1;
            end
            default: begin
                fin = 1'b0;
            end
        endcase

        fin_res.cursor_row = CUR_ROW_W'(n_row);
        fin_res.cursor_col = CUR_COL_W'(n_col);
        if (r_state == ST_DONE) begin
            fin_res = r_pend;
        end

        if (fin && !slot_free) begin
            n_pend = fin_res;
        end
    end

    // result register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        if (fin && slot_free) begin
            n_out       = fin_res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            r_color     <= RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_pend  <= n_pend;
        r_rd_ok <= n_rd_ok;
        if (i_cmd.valid && i_cmd.ready) begin
            r_item.command   <= i_cmd.command;
            r_item.char_code <= i_cmd.char_code;
            r_item.read_row  <= i_cmd.read_row;
            r_item.read_col  <= i_cmd.read_col;
        end
    end

    assign i_cmd.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.cell_value = r_out.cell_value;
    assign o_res.cursor_row = r_out.cursor_row;
    assign o_res.cursor_col = r_out.cursor_col;
    assign o_res.scrolled   = r_out.scrolled;

endmodule

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tcw_addr.sv @@
// ----------------------------------------------------------------------------
// tcw_addr
// maps a screen row and column to a ram address through the row ring
// ----------------------------------------------------------------------------
module tcw_addr #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [$clog2(ROWS)-1:0]         i_row,
    input  logic [$clog2(COLUMNS)-1:0]      i_col,
    input  logic [$clog2(ROWS)-1:0]         i_top,
    output logic [$clog2(ROWS*COLUMNS)-1:0] o_addr
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int SUM_W  = ROW_W + 1;
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] phys;

    assign sum  = {1'b0, i_row} + {1'b0, i_top};
    assign phys = (sum >= SUM_W'(ROWS)) ? (sum - SUM_W'(ROWS)) : sum;

    assign o_addr = ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(i_col);

endmodule

@@ sv/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// port level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [CELL_W-1:0]    i_cell_value,
    input logic [CUR_ROW_W-1:0] i_cursor_row,
    input logic [CUR_COL_W-1:0] i_cursor_col,
    input logic                 i_scrolled
);

    logic [CELL_W+CUR_ROW_W+CUR_COL_W:0] out_payload;
    logic                                out_stall;
    logic                                at_scroll_pos;

    assign out_payload   = {i_cell_value, i_cursor_row, i_cursor_col, i_scrolled};
    assign out_stall     = i_out_valid && !i_out_ready;
    assign at_scroll_pos = (i_cell_value == '0) && (i_cursor_row == CUR_ROW_W'(ROWS - 1))
                           && (i_cursor_col == '0);

    // a stalled item keeps its payload
    `TCW_ASSERT(a_out_hold, out_stall |=> i_out_valid && $stable(out_payload), "stalled item changed")

    `TCW_ASSERT(a_col_range, i_out_valid |-> i_cursor_col < COLUMNS, "cursor column off screen")

    // a scroll leaves the cursor at the start of the last row
    `TCW_ASSERT(a_scroll_pos, i_out_valid && i_scrolled |-> at_scroll_pos, "scroll cursor misplaced")

    // input is closed in the cycle after each accepted item
    `TCW_ASSERT(a_in_gap, i_in_valid && i_in_ready |=> !i_in_ready, "input open after an item")

    // blanking pass keeps input closed after reset
    `TCW_ASSERT_NR(a_init_busy, !i_rst_n |=> !i_in_ready, "item taken during blanking pass")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_cell_value (o_res.cell_value),
    .i_cursor_row (o_res.cursor_row),
    .i_cursor_col (o_res.cursor_col),
    .i_scrolled   (o_res.scrolled)
);

@@ dv/text_console_writer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer. Commands go in over the
// command channel and results come back over the result channel, with random
// idling on both sides. A scoreboard class keeps its own copy of the screen,
// cursor and colour, predicts one result per accepted item and compares each
// returned result field by field. A short directed run covers the field
// extremes and every command. Random phases then mix text runs, newline
// bursts, reads, clears and the unused command under several colours.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int SCREEN_COLS   = 80;
    localparam int SCREEN_ROWS   = 25;
    localparam int SETTLE_CYCLES = SCREEN_ROWS * SCREEN_COLS + 100;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class console_scoreboard;
        logic [CELL_W-1:0]  cells [SCREEN_ROWS * SCREEN_COLS];
        int unsigned        row;
        int unsigned        col;
        logic [COLOR_W-1:0] color;
        t_res               expected_q [$];
        int                 failures;

        function new();
            blank();
            color    = RESET_COLOR;
            failures = 0;
        endfunction

        function void blank();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            row = 0;
            col = 0;
        endfunction

        function void set_color(logic [COLOR_W-1:0] c);
            color = c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // next row, or scroll when already on the last row
        function bit advance_row();
            if (row + 1 < SCREEN_ROWS) begin
                row++;
                return 1'b0;
            end
            for (int i = 0; i + SCREEN_COLS < SCREEN_ROWS * SCREEN_COLS; i++)
                cells[i] = cells[i + SCREEN_COLS];
            for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_ROWS * SCREEN_COLS; i++)
                cells[i] = {color, SPACE_CODE};
            return 1'b1;
        endfunction

        function void note_item(t_item it);
            t_res exp;
            exp = '0;
            case (it.command)
                CMD_WRITE: begin
                    if (it.char_code == NEWLINE_CODE) begin
                        exp.scrolled = advance_row();
                        col = 0;
                    end else begin
                        cells[row * SCREEN_COLS + col] = {color, it.char_code};
                        col++;
                        if (col >= SCREEN_COLS) begin
                            col = 0;
                            exp.scrolled = advance_row();
                        end
                    end
                end
                CMD_READ: begin
                    if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS)
                        exp.cell_value = cells[it.read_row * SCREEN_COLS + it.read_col];
                end
                CMD_CLEAR: begin
                    blank();
                end
                default: begin
                end
            endcase
            exp.cursor_row = row[CUR_ROW_W-1:0];
            exp.cursor_col = col[CUR_COL_W-1:0];
            expected_q.push_back(exp);
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                    $display("unexpected result: cell %h row %0d col %0d scroll %0b",
                             got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
                return;
            end
            exp = expected_q.pop_front();
            if (got.cell_value !== exp.cell_value || got.cursor_row !== exp.cursor_row ||
                got.cursor_col !== exp.cursor_col || got.scrolled !== exp.scrolled) begin
                failures++;
                if (failures <= SHOWN_ERRORS)
                    $display("mismatch: exp %h %0d %0d %0b got %h %0d %0d %0b",
                             exp.cell_value, exp.cursor_row, exp.cursor_col, exp.scrolled,
                             got.cell_value, got.cursor_row, got.cursor_col, got.scrolled);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COLOR_W-1:0] i_cfg_wdata;

    tcw_cmd_if cmd_ch ();
    tcw_res_if res_ch ();

    text_console_writer #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch)
    );

    console_scoreboard sb = new();

    int   send_idle_pct;
    int   recv_idle_pct;
    int   newline_pct;
    int   quiet_cycles;
    t_res seen_res;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // result side stalls
    always @(negedge i_clk) begin
        res_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen_res.cell_value = res_ch.cell_value;
            seen_res.cursor_row = res_ch.cursor_row;
            seen_res.cursor_col = res_ch.cursor_col;
            seen_res.scrolled   = res_ch.scrolled;
            sb.check_result(seen_res);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.command   = it.command;
        cmd_ch.char_code = it.char_code;
        cmd_ch.read_row  = it.read_row;
        cmd_ch.read_col  = it.read_col;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] command, input logic [CHAR_W-1:0] ch,
                               input logic [RROW_W-1:0] r, input logic [RCOL_W-1:0] c);
        t_item it;
        it.command   = command;
        it.char_code = ch;
        it.read_row  = r;
        it.read_col  = c;
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic settle_and_write_color(input logic [COLOR_W-1:0] c);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = c;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_color(c);
    endtask

    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    aim;
        it.char_code = CHAR_W'($urandom_range(0, 255));
        it.read_row  = RROW_W'($urandom_range(0, 31));
        it.read_col  = RCOL_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 999);
        if (pick < 5) begin
            it.command = CMD_CLEAR;
        end else if (pick < 25) begin
            it.command = CMD_UNUSED;
        end else if (pick < 300) begin
            it.command = CMD_READ;
            aim = $urandom_range(0, 9);
            if (aim < 6) begin
                it.read_row = RROW_W'($urandom_range(0, SCREEN_ROWS - 1));
                it.read_col = RCOL_W'($urandom_range(0, SCREEN_COLS - 1));
            end else if (aim < 8) begin
                // around the cursor, where fresh text sits
                it.read_row = sb.row[RROW_W-1:0];
                it.read_col = RCOL_W'($urandom_range(0, SCREEN_COLS - 1));
            end
        end else begin
            it.command = CMD_WRITE;
            if ($urandom_range(0, 99) < newline_pct)
                it.char_code = NEWLINE_CODE;
        end
        return it;
    endfunction

    task automatic run_phase(input int n_items, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n_items; i++) begin
            // switch at random between long text runs and newline bursts
            if (i % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: newline_pct = 1;
                    1: newline_pct = 20;
                    default: newline_pct = 60;
                endcase
            end
            if (i == n_items / 2)
                drain_results();
            send_item(random_item());
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_WRITE;
        cmd_ch.char_code = '0;
        cmd_ch.read_row  = '0;
        cmd_ch.read_col  = '0;
        res_ch.ready     = 1'b0;
        send_idle_pct    = 25;
        recv_idle_pct    = 46;
        newline_pct      = 20;
        quiet_cycles     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset colour, read bounds, char extremes, every command
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'hFF, 5'd24, 7'd79);
        send_fields(CMD_READ, 8'h00, 5'd25, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd80);
        send_fields(CMD_READ, 8'h00, 5'd31, 7'd127);
        send_fields(CMD_WRITE, 8'h41, 5'd31, 7'd127);
        send_fields(CMD_WRITE, 8'h00, 5'd0, 7'd0);
        send_fields(CMD_WRITE, 8'hFF, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd2);
        send_fields(CMD_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd3);
        send_fields(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
        send_fields(CMD_WRITE, SPACE_CODE, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd1, 7'd0);
        send_fields(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd1);
        send_fields(CMD_WRITE, 8'h7E, 5'd0, 7'd0);
        send_fields(CMD_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        send_fields(CMD_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        send_fields(CMD_READ, 8'h00, 5'd0, 7'd0);

        settle_and_write_color(8'h00);
        run_phase(500, 25, 46);
        settle_and_write_color(8'hFF);
        run_phase(500, 46, 25);
        settle_and_write_color(COLOR_W'($urandom_range(1, 254)));
        run_phase(500, 0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d results never arrived", sb.pending());
            sb.failures += sb.pending();
        end
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
